// ----- rtl/pidl_pkg.sv -----
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared types and constants for the positional insert/delete list.
// ----------------------------------------------------------------------------
`default_nettype none

package pidl_pkg;

  // storage shape
  localparam int CAPACITY    = 16;
  localparam int ENTRY_WIDTH = 32;

  // fixed word fields
  localparam int ACT_W   = 2;
  localparam int POS_W   = 5;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // derived widths
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_READ   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_POS = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE
  } op_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    op_e                    op;
    logic [IDX_W-1:0]       idx;
    logic [ENTRY_WIDTH-1:0] value;
  } pidl_cmd_t;

  // per-word result from the controller
  typedef struct packed {
    status_e              status;
    logic                 read_sel;
    logic [COUNT_W-1:0]   count;
  } pidl_res_t;

endpackage

`default_nettype wire

// ----- rtl/pidl_if.sv -----
// ----------------------------------------------------------------------------
// pidl request / response channels
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface pidl_req_if;
  import pidl_pkg::*;

  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [POS_W-1:0]   position;
  logic [DATA_W-1:0]  value;

  modport source (output valid, action, position, value, input ready);
  modport sink   (input valid, action, position, value, output ready);
endinterface

interface pidl_rsp_if;
  import pidl_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [DATA_W-1:0]  read_value;
  logic [COUNT_W-1:0] count;

  modport source (output valid, status, read_value, count, input ready);
  modport sink   (input valid, status, read_value, count, output ready);
endinterface

`default_nettype wire

// ----- rtl/pidl_cell.sv -----
// ----------------------------------------------------------------------------
// pidl_cell
// One list slot: loads, takes from the lower or upper neighbor, or holds.
// ----------------------------------------------------------------------------
`default_nettype none

module pidl_cell (
  input  wire logic                           clk,
  input  wire pidl_pkg::pidl_cmd_t            cmd,
  input  wire logic [pidl_pkg::IDX_W-1:0]     slot,
  input  wire logic [pidl_pkg::ENTRY_WIDTH-1:0] prev_q,
  input  wire logic [pidl_pkg::ENTRY_WIDTH-1:0] next_q,
  output logic      [pidl_pkg::ENTRY_WIDTH-1:0] q
);
  import pidl_pkg::*;

  logic [ENTRY_WIDTH-1:0] q_next;

  always_comb begin
    q_next = q;
    case (cmd.op)
      OP_INSERT: begin
        if (slot == cmd.idx) begin
          q_next = cmd.value;
        end else if (slot > cmd.idx) begin
          q_next = prev_q;
        end
      end
      OP_DELETE: begin
        if (slot >= cmd.idx) begin
          q_next = next_q;
        end
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

`default_nettype wire

// ----- rtl/pidl_ctrl.sv -----
// ----------------------------------------------------------------------------
// pidl_ctrl
// Holds the length, checks position and fullness, drives the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module pidl_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          fire,
  input  wire logic [pidl_pkg::ACT_W-1:0]    action,
  input  wire logic [pidl_pkg::POS_W-1:0]    position,
  input  wire logic [pidl_pkg::DATA_W-1:0]   value,
  output pidl_pkg::pidl_cmd_t                cmd,
  output pidl_pkg::pidl_res_t                res
);
  import pidl_pkg::*;

  logic [LEN_W-1:0] length;
  logic [LEN_W-1:0] length_next;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] len_c;
  logic             pos_zero;
  logic             in_range;
  logic             in_range_ins;
  status_e          status;
  op_e              op;
  logic             read_sel;

  assign pos_c        = CMP_W'(position);
  assign len_c        = CMP_W'(length);
  assign pos_zero     = (position == '0);
  assign in_range     = !pos_zero && (pos_c <= len_c);
  assign in_range_ins = !pos_zero && (pos_c <= len_c + CMP_W'(1));

  always_comb begin
    status      = ST_BAD_POS;
    op          = OP_HOLD;
    read_sel    = 1'b0;
    length_next = length;
    case (action)
      ACT_READ: begin
        if (in_range) begin
          status   = ST_OK;
          read_sel = 1'b1;
        end
      end
      ACT_INSERT: begin
        if (length == LEN_W'(CAPACITY)) begin
          status = ST_FULL;
        end else if (in_range_ins) begin
          status      = ST_OK;
          op          = OP_INSERT;
          length_next = length + LEN_W'(1);
        end
      end
      ACT_DELETE: begin
        if (in_range) begin
          status      = ST_OK;
          op          = OP_DELETE;
          read_sel    = 1'b1;
          length_next = length - LEN_W'(1);
        end
      end
      default: status = ST_BAD_POS;
    endcase
  end

  assign cmd.op    = fire ? op : OP_HOLD;
  assign cmd.idx   = IDX_W'(position - POS_W'(1));
  assign cmd.value = ENTRY_WIDTH'(value);

  assign res.status   = status;
  assign res.read_sel = read_sel;
  assign res.count    = COUNT_W'(length_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (fire) begin
      length <= length_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/positional_insert_delete_list_core.sv -----
// ----------------------------------------------------------------------------
// positional_insert_delete_list_core
// Packed list of CAPACITY entries with read, insert and delete by position.
// ----------------------------------------------------------------------------
// Usage:
//   req  : request word {action, position, value}; position is 1-based.
//          action 0 reads, 1 inserts (shifts later entries up),
//          2 deletes (returns the entry, shifts later entries down).
//   rsp  : one response word per request {status, read_value, count}.
//          status 0 ok, 1 full (insert only), 2 bad position / bad action.
//          read_value is zero for insert and for any error; count is the
//          length after the request.
// Timing:
//   The response is registered: the word accepted at one edge shows on rsp right
//   after it. One request per cycle is sustained: the whole cell chain
//   shifts in the same cycle, and the response register frees up as it is
//   taken, so req.ready = !rsp.valid || rsp.ready.
// Stall: while rsp is held off, the response register holds its word and
//   req.ready drops; no request is lost.
// Reset: rst (synchronous) clears the length and the response valid. The
//   cells are not cleared; slots at or beyond the length are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_insert_delete_list_core (
  input  wire logic  clk,
  input  wire logic  rst,
  pidl_req_if.sink   req,
  pidl_rsp_if.source rsp
);
  import pidl_pkg::*;

  pidl_cmd_t              cmd;
  pidl_res_t              res;
  logic                   fire;
  logic [ENTRY_WIDTH-1:0] cell_q [CAPACITY];
  logic [DATA_W-1:0]      rd_value;

  // response register
  logic                   out_valid;
  logic [STAT_W-1:0]      out_status;
  logic [DATA_W-1:0]      out_value;
  logic [COUNT_W-1:0]     out_count;

  assign req.ready = !out_valid || rsp.ready;
  assign fire      = req.valid && req.ready;

  pidl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .action   (req.action),
    .position (req.position),
    .value    (req.value),
    .cmd      (cmd),
    .res      (res)
  );

  // Chain of slots; each takes from its neighbor on a shift. The ends see
  // zero, which only lands in slots past the length.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] prev_q;
    logic [ENTRY_WIDTH-1:0] next_q;

    if (g == 0) begin : g_first
      assign prev_q = '0;
    end else begin : g_mid_lo
      assign prev_q = cell_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign next_q = '0;
    end else begin : g_mid_hi
      assign next_q = cell_q[g+1];
    end

    pidl_cell u_cell (
      .clk    (clk),
      .cmd    (cmd),
      .slot   (IDX_W'(g)),
      .prev_q (prev_q),
      .next_q (next_q),
      .q      (cell_q[g])
    );
  end

  // Read/delete tap: the old entry at the position, before this shift.
  assign rd_value = res.read_sel ? DATA_W'(cell_q[cmd.idx]) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= res.status;
      out_value  <= rd_value;
      out_count  <= res.count;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.read_value = out_value;
  assign rsp.count      = out_count;

endmodule

`default_nettype wire

// ----- rtl/pidl_checker.sv -----
// ----------------------------------------------------------------------------
// pidl_checker
// Port-level checks for the positional insert/delete list.
// ----------------------------------------------------------------------------
`default_nettype none

module pidl_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          req_valid,
  input wire logic                          req_ready,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic [pidl_pkg::STAT_W-1:0]   rsp_status,
  input wire logic [pidl_pkg::DATA_W-1:0]   rsp_read_value,
  input wire logic [pidl_pkg::COUNT_W-1:0]  rsp_count
);
  import pidl_pkg::*;

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_read_value) && $stable(rsp_count))
    else $error("response changed while stalled");

  // accepted request answers on the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("no response one cycle after request");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_count <= COUNT_W'(CAPACITY))
    else $error("count above capacity");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_read_value == '0)
    else $error("nonzero value on error");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FULL |-> rsp_count == COUNT_W'(CAPACITY))
    else $error("full reported below capacity");

endmodule

bind positional_insert_delete_list_core pidl_checker u_pidl_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_read_value (rsp.read_value),
  .rsp_count      (rsp.count)
);

`default_nettype wire

// ----- verif/positional_insert_delete_list_core_test.sv -----
// ----------------------------------------------------------------------------
// positional_insert_delete_list_core_test
// Self-checking bench for the positional list: drives request words with
// random bursts and gaps, holds off responses on a random pattern, and
// checks every response word against a tracked copy of the list contents.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_insert_delete_list_core_test;
  import pidl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // action code outside the enum; the block must answer it as a bad position
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam int IDLE_LIMIT   = 1000;  // cycles with no word moved on either side
  localparam int RANDOM_WORDS = 1625;  // plus the directed words, about 1650 total
  localparam int TAIL_CYCLES  = 4;     // margin after the drain

  // one expected response word
  typedef struct packed {
    status_e             status;
    logic [DATA_W-1:0]   read_value;
    logic [COUNT_W-1:0]  count;
  } rsp_word_t;

  // Tracks the list contents and the responses still owed by the block.
  class list_tracker;
    logic [ENTRY_WIDTH-1:0] slot [CAPACITY];
    int unsigned            fill;
    rsp_word_t              owed[$];
    int unsigned            errors;
    int unsigned            shown;

    function new();
      fill   = 0;
      errors = 0;
      shown  = 0;
    endfunction

    // apply one accepted request to the tracked list and queue its response
    function void note_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                               logic [DATA_W-1:0] val);
      rsp_word_t w;
      int        j;
      w.status     = ST_OK;
      w.read_value = '0;
      case (act)
        ACT_READ: begin
          if (pos == 0 || pos > fill) w.status = ST_BAD_POS;
          else w.read_value = DATA_W'(slot[pos-1]);
        end
        ACT_INSERT: begin
          // full is checked before the position
          if (fill >= CAPACITY) w.status = ST_FULL;
          else if (pos == 0 || pos > fill + 1) w.status = ST_BAD_POS;
          else begin
            for (j = fill; j > pos - 1; j--) slot[j] = slot[j-1];
            slot[pos-1] = val[ENTRY_WIDTH-1:0];
            fill++;
          end
        end
        ACT_DELETE: begin
          if (pos == 0 || pos > fill) w.status = ST_BAD_POS;
          else begin
            w.read_value = DATA_W'(slot[pos-1]);
            fill--;
            for (j = pos - 1; j < fill; j++) slot[j] = slot[j+1];
          end
        end
        default: w.status = ST_BAD_POS;
      endcase
      w.count = fill[COUNT_W-1:0];
      owed.push_back(w);
    endfunction

    // compare one accepted response word with the oldest one owed
    function void check_response(logic [STAT_W-1:0] st, logic [DATA_W-1:0] rv,
                                 logic [COUNT_W-1:0] cnt);
      rsp_word_t w;
      if (owed.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected rsp word: status %0d read_value %h count %0d",
                   st, rv, cnt);
        end
        return;
      end
      w = owed.pop_front();
      if (st !== w.status || rv !== w.read_value || cnt !== w.count) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display(
            "rsp mismatch (exp/got): status %0d/%0d read_value %h/%h count %0d/%0d",
            w.status, st, w.read_value, rv, w.count, cnt);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  pidl_req_if req_ch();
  pidl_rsp_if rsp_ch();

  positional_insert_delete_list_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  list_tracker tracker = new();

  // sender burst state
  int unsigned burst_left;
  int unsigned idle_cycles = 0;
  bit          growing;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run if no word moves on either side for too long.
  // Signals are driven nonblocking at the edge, so these are pre-edge values.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("[positional_insert_delete_list_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Response checking. A response taken at this edge belongs to a request
  // noted at an earlier edge, so there is no ordering issue with the driver.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      tracker.check_response(rsp_ch.status, rsp_ch.read_value, rsp_ch.count);
  end

  // --------------------------------------------------------------------------
  // Receiver: phases of random length, each with its own stall rate, plus
  // long hold-offs so the response register fills and req.ready drops while
  // the sender keeps offering. The first one is forced well into the run.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned cyc;
    int unsigned phase_len;
    int unsigned stall_pct;
    int unsigned hold_len;
    bit          held;
    rsp_ch.ready <= 1'b0;
    cyc  = 0;
    held = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ((!held && cyc >= 600) || $urandom_range(99) < 3) begin
        held     = 1;
        hold_len = $urandom_range(100, 60);
        rsp_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        cyc += hold_len;
      end
      phase_len = $urandom_range(200, 20);
      case ($urandom_range(3))
        0:       stall_pct = 0;   // no stalls at all
        1:       stall_pct = 25;
        2:       stall_pct = 60;
        default: stall_pct = 90;
      endcase
      repeat (phase_len) begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        @(posedge clk);
        cyc++;
      end
    end
  end

  // Offer one request word and hold it until taken; the word is noted in the
  // tracker at the accepting edge, then the sender may go quiet for a while.
  task automatic send_word(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                           logic [DATA_W-1:0] val);
    req_ch.valid    <= 1'b1;
    req_ch.action   <= act;
    req_ch.position <= pos;
    req_ch.value    <= val;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_request(act, pos, val);
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(120, 40)
                                             : $urandom_range(30, 1);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Random request shaped by the tracked length: the list is driven toward
  // full and back toward empty so both ends get exercised repeatedly.
  task automatic send_random_word();
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    int unsigned      lim;
    int unsigned      r;
    if (tracker.fill == CAPACITY && $urandom_range(1) == 0) growing = 0;
    if (tracker.fill == 0) growing = 1;
    if ($urandom_range(49) == 0) growing = !growing;
    r = $urandom_range(99);
    if (r < 8) begin
      // noise: unused action, position zero, or position past the range
      case ($urandom_range(2))
        0: begin
          act = ACT_UNUSED;
          pos = POS_W'($urandom_range(31));
        end
        1: begin
          act = action_e'($urandom_range(2));
          pos = '0;
        end
        default: begin
          act = action_e'($urandom_range(2));
          lim = (act == ACT_INSERT) ? tracker.fill + 1 : tracker.fill;
          pos = POS_W'($urandom_range(31, lim + 1));
        end
      endcase
    end else begin
      r = $urandom_range(99);
      if (r < 25) act = ACT_READ;
      else if (growing) act = (r < 80) ? ACT_INSERT : ACT_DELETE;
      else act = (r < 80) ? ACT_DELETE : ACT_INSERT;
      lim = (act == ACT_INSERT) ? tracker.fill + 1 : tracker.fill;
      if (lim == 0) lim = 1;   // read/delete on an empty list: bad position
      // favor the two ends of the list, where the shift is shortest/longest
      case ($urandom_range(2))
        0:       pos = POS_W'(1);
        1:       pos = POS_W'(lim);
        default: pos = POS_W'($urandom_range(lim, 1));
      endcase
    end
    send_word(act, pos, pick_value());
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed corner words, random words, drain, verdict.
  // --------------------------------------------------------------------------
  initial begin
    int i;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.action   <= ACT_READ;
    req_ch.position <= '0;
    req_ch.value    <= '0;
    burst_left      = 5;
    growing         = 1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty list: every read and delete is a bad position
    send_word(ACT_READ, POS_W'(1), '0);
    send_word(ACT_DELETE, POS_W'(1), '0);
    send_word(ACT_INSERT, POS_W'(0), 32'hA5A5_A5A5);   // position zero
    send_word(ACT_INSERT, POS_W'(2), 32'h5A5A_5A5A);   // one past length + 1
    send_word(ACT_UNUSED, POS_W'(31), '1);             // unused action code

    // fill to capacity: head, tail and middle inserts, extreme values first
    for (i = 0; i < CAPACITY; i++) begin
      case (i % 3)
        0:       send_word(ACT_INSERT, POS_W'(1), (i == 0) ? '0 : $urandom);
        1:       send_word(ACT_INSERT, POS_W'(tracker.fill + 1),
                           (i == 1) ? '1 : $urandom);
        default: send_word(ACT_INSERT, POS_W'(tracker.fill / 2 + 1), $urandom);
      endcase
    end

    send_word(ACT_READ, POS_W'(CAPACITY), '0);        // last entry
    send_word(ACT_READ, POS_W'(CAPACITY + 1), '0);    // past the end
    send_word(ACT_INSERT, POS_W'(1), $urandom);       // full
    send_word(ACT_INSERT, POS_W'(0), $urandom);       // full wins over bad position
    send_word(ACT_DELETE, POS_W'(CAPACITY), '0);      // delete the tail
    send_word(ACT_DELETE, POS_W'(1), '0);             // delete the head, shift all down
    send_word(ACT_READ, POS_W'(1), '0);

    for (i = 0; i < RANDOM_WORDS; i++) send_random_word();

    req_ch.valid <= 1'b0;
    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (tracker.errors == 0 && tracker.owed.size() == 0) begin
      $display("[positional_insert_delete_list_core] OK");
    end else begin
      $display("[positional_insert_delete_list_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
